>>> rtl/erf_pkg.sv
// Shared types and constants of the epoch replay filter.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
package erf_pkg;

  localparam int TableEntries = 1024;
  localparam int KeyBytes     = 16;
  localparam int SlotW        = $clog2(TableEntries);
  localparam int HomeW        = 10;
  localparam int KeyW         = 64;
  localparam int EpochW       = 32;
  localparam int NumTables    = 3;
  localparam int TblW         = 2;
  localparam int QueueDepth   = 4;
  localparam int QPtrW        = $clog2(QueueDepth);

  localparam logic [TblW-1:0] RoleOld  = 2'd0;
  localparam logic [TblW-1:0] RoleCur  = 2'd1;
  localparam logic [TblW-1:0] RoleNext = 2'd2;

  typedef enum logic [2:0] {
    V_FRESH  = 3'd0,
    V_REPLAY = 3'd1,
    V_EPOCH  = 3'd2,
    V_LENGTH = 3'd3,
    V_FULL   = 3'd4
  } verdict_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_CLEAR,
    ST_DONE
  } erf_state_e;

  // One classified item as it travels from the front to the back.
  typedef struct packed {
    logic              is_epoch;
    logic              probe;
    verdict_e          verdict;
    logic [TblW-1:0]   tbl;
    logic [SlotW-1:0]  home;
    logic [KeyW-1:0]   key;
    logic [EpochW-1:0] cur_epoch;
  } erf_cmd_t;

  typedef struct packed {
    logic init_busy;
  } erf_status_t;

  // The home slot is reduced to the table range by keeping its low bits.
  function automatic logic [SlotW-1:0] home_to_slot(input logic [HomeW-1:0] home);
    logic [SlotW+HomeW-1:0] wide;
    wide = {{SlotW{1'b0}}, home};
    return wide[SlotW-1:0];
  endfunction

endpackage

>>> rtl/erf_queue.sv
// Small command queue between the classifying front and the table back end.
// Depends on erf_pkg.
`timescale 1ns / 1ps
module erf_queue import erf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  erf_cmd_t push_data_i,
  output logic     full_o,
  input  logic     pop_i,
  output erf_cmd_t head_o,
  output logic     empty_o
);

  erf_cmd_t         slots_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPtrW:0]   count_q, count_d;

  assign full_o  = (count_q == (QPtrW+1)'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign head_o  = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + (QPtrW+1)'(push_i) - (QPtrW+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> rtl/erf_front.sv
// Front end: accepts items, checks length and epoch, tracks epoch numbers
// and the table rotation, and queues classified commands. Depends on erf_pkg.
`timescale 1ns / 1ps
module erf_front import erf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               op_i,
  input  logic [EpochW-1:0]  epoch_tag_i,
  input  logic [15:0]        key_length_i,
  input  logic [HomeW-1:0]   home_slot_i,
  input  logic [31:0]        key_high_i,
  input  logic [31:0]        key_low_i,
  input  erf_status_t        status_i,
  input  logic               q_full_i,
  output logic               push_o,
  output erf_cmd_t           cmd_o
);

  logic [EpochW-1:0] old_q, old_d, cur_q, cur_d, next_q, next_d;
  logic [TblW-1:0]   rot_q [NumTables];
  logic [TblW-1:0]   rot_d [NumTables];

  assign in_ready_o = !q_full_i && !status_i.init_busy;
  assign push_o     = in_valid_i && in_ready_o;

  always_comb begin
    old_d  = old_q;
    cur_d  = cur_q;
    next_d = next_q;
    rot_d  = rot_q;
    cmd_o.is_epoch  = op_i;
    cmd_o.probe     = 1'b0;
    cmd_o.verdict   = V_FRESH;
    cmd_o.tbl       = rot_q[RoleOld];
    cmd_o.home      = home_to_slot(home_slot_i);
    cmd_o.key       = {key_high_i, key_low_i};
    cmd_o.cur_epoch = cur_q;
    if (op_i) begin
      // The freed old table becomes the next table and is cleared behind.
      rot_d[RoleOld]  = rot_q[RoleCur];
      rot_d[RoleCur]  = rot_q[RoleNext];
      rot_d[RoleNext] = rot_q[RoleOld];
      old_d  = cur_q;
      cur_d  = next_q;
      next_d = next_q + 1'b1;
      cmd_o.cur_epoch = next_q;
    end else if (key_length_i != 16'(KeyBytes)) begin
      cmd_o.verdict = V_LENGTH;
    end else if (epoch_tag_i == old_q) begin
      cmd_o.probe = 1'b1;
      cmd_o.tbl   = rot_q[RoleOld];
    end else if (epoch_tag_i == cur_q) begin
      cmd_o.probe = 1'b1;
      cmd_o.tbl   = rot_q[RoleCur];
    end else if (epoch_tag_i == next_q) begin
      cmd_o.probe = 1'b1;
      cmd_o.tbl   = rot_q[RoleNext];
    end else begin
      cmd_o.verdict = V_EPOCH;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      old_q  <= 32'd0;
      cur_q  <= 32'd1;
      next_q <= 32'd2;
      rot_q[RoleOld]  <= 2'd0;
      rot_q[RoleCur]  <= 2'd1;
      rot_q[RoleNext] <= 2'd2;
    end else if (push_o) begin
      old_q  <= old_d;
      cur_q  <= cur_d;
      next_q <= next_d;
      rot_q  <= rot_d;
    end
  end

endmodule

>>> rtl/erf_back.sv
// Back end: holds the three key tables, runs linear probes, clears tables
// and drives the result register. Depends on erf_pkg.
`timescale 1ns / 1ps
module erf_back import erf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_empty_i,
  input  erf_cmd_t           head_i,
  output logic               pop_o,
  output erf_status_t        status_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               fresh_o,
  output logic [2:0]         verdict_o,
  output logic [EpochW-1:0]  current_epoch_o
);

  localparam logic [SlotW-1:0] LastSlot = SlotW'(TableEntries - 1);

  erf_state_e        state_q, state_d;
  erf_cmd_t          cmd_q;
  logic [SlotW-1:0]  cnt_q, cnt_d;
  logic [SlotW-1:0]  pos_q, pos_d, pos_next;
  verdict_e          res_q, res_d;
  logic              out_valid_q;
  logic              fresh_q;
  logic [2:0]        verdict_q;
  logic [EpochW-1:0] epoch_q;

  // Each entry holds a valid bit above the 64-bit key.
  logic [KeyW:0]          mem [NumTables][TableEntries];
  logic [KeyW:0]          rdata_q;
  logic                   rd_en;
  logic [SlotW-1:0]       rd_addr;
  logic [NumTables-1:0]   wr_en;
  logic [SlotW-1:0]       wr_addr;
  logic [KeyW:0]          wr_data;
  logic                   out_free;
  logic                   load_out;
  logic                   hit;

  assign out_free   = !out_valid_q || out_ready_i;
  assign pos_next   = (pos_q == LastSlot) ? '0 : pos_q + 1'b1;
  assign hit        = (rdata_q[KeyW-1:0] == cmd_q.key);
  assign status_o.init_busy = (state_q == ST_INIT);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    pos_d   = pos_q;
    res_d   = res_q;
    case (state_q)
      ST_INIT: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LastSlot) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!q_empty_i) begin
          cnt_d = '0;
          pos_d = head_i.home;
          res_d = head_i.verdict;
          if (head_i.is_epoch) begin
            state_d = ST_CLEAR;
          end else if (head_i.probe) begin
            state_d = ST_READ;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_READ: state_d = ST_CHECK;
      ST_CHECK: begin
        if (!rdata_q[KeyW]) begin
          res_d   = V_FRESH;
          state_d = ST_DONE;
        end else if (hit) begin
          res_d   = V_REPLAY;
          state_d = ST_DONE;
        end else if (cnt_q == LastSlot) begin
          res_d   = V_FULL;
          state_d = ST_DONE;
        end else begin
          cnt_d = cnt_q + 1'b1;
          pos_d = pos_next;
        end
      end
      ST_CLEAR: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LastSlot) begin
          res_d   = V_FRESH;
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    pop_o    = 1'b0;
    rd_en    = 1'b0;
    rd_addr  = pos_q;
    wr_en    = '0;
    wr_addr  = cnt_q;
    wr_data  = '0;
    load_out = 1'b0;
    case (state_q)
      ST_INIT: wr_en = '1;
      ST_IDLE: pop_o = !q_empty_i;
      ST_READ: rd_en = 1'b1;
      ST_CHECK: begin
        if (!rdata_q[KeyW]) begin
          wr_en[cmd_q.tbl] = 1'b1;
          wr_addr = pos_q;
          wr_data = {1'b1, cmd_q.key};
        end else if (!hit && (cnt_q != LastSlot)) begin
          rd_en   = 1'b1;
          rd_addr = pos_next;
        end
      end
      ST_CLEAR: wr_en[cmd_q.tbl] = 1'b1;
      ST_DONE:  load_out = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    for (int b = 0; b < NumTables; b++) begin
      if (wr_en[b]) begin
        mem[b][wr_addr] <= wr_data;
      end
    end
    if (rd_en) begin
      rdata_q <= mem[cmd_q.tbl][rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    res_q <= res_d;
    if (pop_o) begin
      cmd_q <= head_i;
    end
    if (load_out) begin
      fresh_q   <= !cmd_q.is_epoch && (res_q == V_FRESH);
      verdict_q <= cmd_q.is_epoch ? V_FRESH : res_q;
      epoch_q   <= cmd_q.cur_epoch;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign fresh_o         = fresh_q;
  assign verdict_o       = verdict_q;
  assign current_epoch_o = epoch_q;

endmodule

>>> rtl/epoch_replay_filter_top.sv
// Top level of the epoch replay filter: stream ports, front end, command
// queue and table back end. Depends on erf_pkg, erf_front, erf_queue, erf_back.
`timescale 1ns / 1ps
// Usage:
// The slave stream carries one item per transfer. tuser is the operation:
// 0 checks a key against the table of its epoch and stores it if new, 1
// advances the epoch. The master stream returns exactly one result per item,
// in order. A check with a bad length or an unknown epoch is answered
// without touching the tables. A check probes one slot per cycle from its
// home slot; a full table costs 1024 probes. An epoch change clears the
// freed table one slot per cycle. The table memory's single read port sets
// the probe rate. The front end classifies and queues up to four commands,
// so it keeps taking items while the back end probes or clears.
// After reset all three tables are cleared together, slot by slot, while
// s_axis_tready stays low. When the receiver stalls, the result waits
// in the output register, the back end holds, and the queue fills until
// s_axis_tready falls.
module epoch_replay_filter_top import erf_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // tdata: epoch_tag[31:0], key_length[47:32], home_slot[57:48],
  // key_high[89:58], key_low[121:90], zeros[127:122]
  input  logic [127:0]  s_axis_tdata,
  // tuser: op[0]
  input  logic          s_axis_tuser,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // tdata: fresh[0], verdict[3:1], current_epoch[35:4], zeros[39:36]
  output logic [39:0]   m_axis_tdata
);

  erf_status_t status;
  erf_cmd_t    push_cmd;
  erf_cmd_t    head_cmd;
  logic        push;
  logic        pop;
  logic        q_full;
  logic        q_empty;
  logic        fresh;
  logic [2:0]  verdict;
  logic [EpochW-1:0] cur_epoch;

  erf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .op_i         (s_axis_tuser),
    .epoch_tag_i  (s_axis_tdata[31:0]),
    .key_length_i (s_axis_tdata[47:32]),
    .home_slot_i  (s_axis_tdata[57:48]),
    .key_high_i   (s_axis_tdata[89:58]),
    .key_low_i    (s_axis_tdata[121:90]),
    .status_i     (status),
    .q_full_i     (q_full),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  erf_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (q_full),
    .pop_i       (pop),
    .head_o      (head_cmd),
    .empty_o     (q_empty)
  );

  erf_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_empty_i       (q_empty),
    .head_i          (head_cmd),
    .pop_o           (pop),
    .status_o        (status),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .fresh_o         (fresh),
    .verdict_o       (verdict),
    .current_epoch_o (cur_epoch)
  );

  assign m_axis_tdata = {4'd0, cur_epoch, verdict, fresh};

endmodule

>>> dv/testbench.sv
// Self-checking testbench of the epoch replay filter top level.
// Depends on erf_pkg and epoch_replay_filter_top; predicts each result in-house.
`timescale 1ns / 1ps
module testbench;
  import erf_pkg::*;

  localparam int SlotCount = 1024;
  localparam logic OpCheck = 1'b0;
  localparam logic OpAdvance = 1'b1;
  localparam int IdleLimit = 20000;

  // Laid out like the result tdata: fresh in the lowest bit.
  typedef struct packed {
    logic [31:0] cur_epoch;
    verdict_e    verdict;
    logic        fresh;
  } filter_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  // tdata: epoch_tag, key_length, home_slot, key_high, key_low, zeros
  logic [127:0] s_axis_tdata = '0;
  // tuser: op
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // tdata: fresh, verdict, current_epoch, zeros
  logic [39:0] m_axis_tdata;

  epoch_replay_filter_top dut (.*);

  always #5 clk_i = ~clk_i;

  // Predictor state: three physical tables and their role mapping.
  logic [63:0] key_store [3][SlotCount];
  bit          slot_used [3][SlotCount];
  int          role_table [3];
  logic [31:0] epoch_old, epoch_cur, epoch_next;
  filter_result_t pending_results[$];
  int  failures = 0;
  int  idle_cycles = 0;
  bit  long_stall = 0;
  bit  sender_bursty = 1;

  task automatic reset_predictor();
    foreach (slot_used[t, s]) begin
      slot_used[t][s] = 0;
      key_store[t][s] = '0;
    end
    role_table = '{0, 1, 2};
    epoch_old = 0;
    epoch_cur = 1;
    epoch_next = 2;
  endtask

  function automatic verdict_e probe_table(int role, logic [9:0] home, logic [63:0] key);
    int t;
    int pos;
    t = role_table[role];
    pos = home % SlotCount;
    for (int n = 0; n < SlotCount; n++) begin
      if (!slot_used[t][pos]) begin
        slot_used[t][pos] = 1;
        key_store[t][pos] = key;
        return V_FRESH;
      end
      if (key_store[t][pos] == key) return V_REPLAY;
      pos = (pos + 1) % SlotCount;
    end
    return V_FULL;
  endfunction

  function automatic filter_result_t predict_filter(logic op, logic [127:0] d);
    filter_result_t r;
    int freed;
    verdict_e v;
    if (op == OpAdvance) begin
      freed = role_table[0];
      role_table[0] = role_table[1];
      role_table[1] = role_table[2];
      role_table[2] = freed;
      for (int s = 0; s < SlotCount; s++) begin
        slot_used[freed][s] = 0;
        key_store[freed][s] = '0;
      end
      epoch_old = epoch_cur;
      epoch_cur = epoch_next;
      epoch_next = epoch_next + 1;
      r.fresh = 0;
      r.verdict = V_FRESH;
    end else begin
      if (d[47:32] != KeyBytes) v = V_LENGTH;
      else if (d[31:0] == epoch_old) v = probe_table(0, d[57:48], {d[89:58], d[121:90]});
      else if (d[31:0] == epoch_cur) v = probe_table(1, d[57:48], {d[89:58], d[121:90]});
      else if (d[31:0] == epoch_next) v = probe_table(2, d[57:48], {d[89:58], d[121:90]});
      else v = V_EPOCH;
      r.fresh = (v == V_FRESH);
      r.verdict = v;
    end
    r.cur_epoch = epoch_cur;
    return r;
  endfunction

  // Drive one item, wait for the transfer, then record its expected result.
  task automatic send_item(logic op, logic [31:0] tag, logic [15:0] len, logic [9:0] home,
                           logic [31:0] kh, logic [31:0] kl);
    logic [127:0] d;
    d = {6'b0, kl, kh, home, len, tag};
    if (sender_bursty && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tuser = op;
    s_axis_tdata = d;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(predict_filter(op, d));
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic check_key(logic [31:0] tag, logic [9:0] home, logic [31:0] kh, logic [31:0] kl);
    send_item(OpCheck, tag, 16'(KeyBytes), home, kh, kl);
  endtask

  task automatic advance_epoch();
    send_item(OpAdvance, $urandom, 16'($urandom), 10'($urandom), $urandom, $urandom);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  // Result checker.
  always @(posedge clk_i) begin
    filter_result_t want;
    filter_result_t got;
    if (m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[35:0];
      if (pending_results.size() == 0) begin
        $error("result with no expectation: %h", m_axis_tdata);
        failures++;
      end else begin
        want = pending_results.pop_front();
        if (got.fresh !== want.fresh) begin
          $error("fresh expected %0d actual %0d", want.fresh, got.fresh);
          failures++;
        end
        if (got.verdict !== want.verdict) begin
          $error("verdict expected %0d actual %0d", want.verdict, got.verdict);
          failures++;
        end
        if (got.cur_epoch !== want.cur_epoch) begin
          $error("current_epoch expected %0d actual %0d", want.cur_epoch, got.cur_epoch);
          failures++;
        end
      end
    end
  end

  // Receiver stall pattern, with a long hold-off on request.
  always @(negedge clk_i) begin
    if (!rst_ni || long_stall) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(0, 9) > 2);
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || long_stall)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLimit) begin
      $display("epoch_replay_filter_top: mismatch");
      $finish;
    end
  end

  task automatic test_directed();
    check_key(epoch_cur, 10'd0, 32'h0, 32'h0);
    check_key(epoch_cur, 10'd0, 32'h0, 32'h0);
    check_key(epoch_cur, 10'h3FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    check_key(epoch_cur, 10'h3FF, 32'h1234, 32'h5678);
    check_key(epoch_cur, 10'h3FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    check_key(epoch_old, 10'd5, 32'hA, 32'hB);
    check_key(epoch_next, 10'd5, 32'hA, 32'hB);
    check_key(epoch_next, 10'd5, 32'hA, 32'hB);
    send_item(OpCheck, epoch_cur, 16'd0, 10'd1, 32'd1, 32'd1);
    send_item(OpCheck, epoch_cur, 16'hFFFF, 10'd1, 32'd1, 32'd1);
    send_item(OpCheck, 32'h7777, 16'd15, 10'd1, 32'd1, 32'd1);
    check_key(32'hFFFF_FFFF, 10'd3, 32'd3, 32'd3);
    check_key(32'h8000_0000, 10'd3, 32'd3, 32'd3);
    advance_epoch();
    check_key(epoch_old, 10'd5, 32'hA, 32'hB);
    check_key(epoch_cur, 10'd5, 32'hA, 32'hB);
    check_key(epoch_next, 10'd0, 32'd0, 32'd0);
    advance_epoch();
    check_key(epoch_old, 10'd0, 32'h0, 32'h0);
  endtask

  // Fill the next table to the brim, then check a full-table rejection.
  task automatic test_full_table();
    sender_bursty = 0;
    for (int s = 0; s < SlotCount; s++) check_key(epoch_next, 10'(s), 32'hF000 + s, s);
    check_key(epoch_next, 10'd17, 32'hDEAD, 32'hBEEF);
    check_key(epoch_next, 10'd1023, 32'hF000 + 1023, 32'd1023);
    sender_bursty = 1;
    wait_drained();
    advance_epoch();
    advance_epoch();
  endtask

  task automatic test_random(int count);
    logic [31:0] tag;
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      case ($urandom_range(0, 3))
        0: tag = epoch_old;
        1: tag = epoch_cur;
        2: tag = epoch_next;
        default: tag = ($urandom_range(0, 3) == 0) ? $urandom : epoch_cur;
      endcase
      if (pick < 2) advance_epoch();
      else if (pick < 8)
        send_item(OpCheck, tag, 16'($urandom), 10'($urandom), $urandom, $urandom);
      else if (pick < 50)
        check_key(tag, 10'($urandom_range(0, 15)), $urandom_range(0, 3), $urandom_range(0, 7));
      else check_key(tag, 10'($urandom), $urandom, $urandom);
    end
  endtask

  task automatic test_backpressure();
    long_stall = 1;
    fork
      test_random(30);
      repeat (400) @(negedge clk_i);
    join_any
    long_stall = 0;
    wait fork;
    wait_drained();
  endtask

  initial begin
    reset_predictor();
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_backpressure();
    test_random(400);
    wait_drained();
    test_full_table();
    test_random(400);
    wait_drained();
    repeat (2000) @(negedge clk_i);
    if (failures == 0 && pending_results.size() == 0) begin
      $display("epoch_replay_filter_top: match");
    end else begin
      $display("epoch_replay_filter_top: mismatch");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/erf_pkg.sv
rtl/erf_queue.sv
rtl/erf_front.sv
rtl/erf_back.sv
rtl/epoch_replay_filter_top.sv
dv/testbench.sv
